// File: rtl/cda_pkg.sv
// shared types, widths and calendar constants for the calendar date adder
package cda_pkg;

   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int ADD_DAY_W   = 10;
   localparam int ADD_MON_W   = 8;
   localparam int ADD_YEAR_W  = 8;

   // working widths: day sum up to 1054, month sum up to 270, year up to about 16700
   localparam int WDAY_W      = 11;
   localparam int WMON_W      = 9;
   localparam int WYEAR_W     = 15;
   localparam int QUOT_W      = 11;
   localparam int REM_W       = 5;

   localparam logic [WMON_W-1:0]  MONTHS_PER_YEAR = 9'd12;
   localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
   localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS   = 5'd29;
   localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'h3FFF;

   // floor(y / 25) = (y * 41944) >> 20 for every 15-bit y
   localparam int                RECIP_W      = 16;
   localparam logic [RECIP_W-1:0] RECIP_25    = 16'd41944;
   localparam int                RECIP_SHIFT  = 20;
   localparam int                PROD_W       = WYEAR_W + RECIP_W;
   localparam logic [REM_W-1:0]  REM_25_LAST  = 5'd24;
   localparam logic [WYEAR_W-1:0] DIVISOR_25  = 15'd25;

   typedef struct packed {
      logic load;
      logic mod_div;
      logic mod_rem;
      logic fold_step;
      logic walk_step;
      logic out_write;
   } cmd_type;

   typedef struct packed {
      logic fold_more;
      logic walk_more;
   } status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? FEB_LEAP_DAYS : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/cda_if.sv
// request and response channel interfaces of the calendar date adder
interface cda_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cda_pkg::DAY_W-1:0]            start_day;
   logic [cda_pkg::MONTH_W-1:0]          start_month;
   logic [cda_pkg::YEAR_W-1:0]           start_year;
   logic [cda_pkg::ADD_DAY_W-1:0]        add_days;
   logic [cda_pkg::ADD_MON_W-1:0]        add_months;
   logic [cda_pkg::ADD_YEAR_W-1:0]       add_years;

   modport source (output valid, start_day, start_month, start_year,
                          add_days, add_months, add_years,
                   input  ready);
   modport sink   (input  valid, start_day, start_month, start_year,
                          add_days, add_months, add_years,
                   output ready);
endinterface

interface cda_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cda_pkg::DAY_W-1:0]            result_day;
   logic [cda_pkg::MONTH_W-1:0]          result_month;
   logic [cda_pkg::YEAR_W-1:0]           result_year;

   modport source (output valid, result_day, result_month, result_year,
                   input  ready);
   modport sink   (input  valid, result_day, result_month, result_year,
                   output ready);
endinterface

// File: rtl/cda_ctrl.sv
// controller state machine of the calendar date adder
module cda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cda_pkg::status_type  status,
   output cda_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD_DIV,
      ST_MOD_REM,
      ST_FOLD,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD_DIV;
            end
         end
         ST_MOD_DIV: begin
            cmd.mod_div = 1'b1;
            state_in    = ST_MOD_REM;
         end
         ST_MOD_REM: begin
            cmd.mod_rem = 1'b1;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            if (status.fold_more) begin
               cmd.fold_step = 1'b1;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_more) begin
               cmd.walk_step = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/cda_datapath.sv
// datapath of the calendar date adder: working date, year residue and result register
module cda_datapath (
   input  logic                              clock,
   input  logic [cda_pkg::DAY_W-1:0]         start_day,
   input  logic [cda_pkg::MONTH_W-1:0]       start_month,
   input  logic [cda_pkg::YEAR_W-1:0]        start_year,
   input  logic [cda_pkg::ADD_DAY_W-1:0]     add_days,
   input  logic [cda_pkg::ADD_MON_W-1:0]     add_months,
   input  logic [cda_pkg::ADD_YEAR_W-1:0]    add_years,
   input  cda_pkg::cmd_type                  cmd,
   output cda_pkg::status_type               status,
   output logic [cda_pkg::DAY_W-1:0]         result_day,
   output logic [cda_pkg::MONTH_W-1:0]       result_month,
   output logic [cda_pkg::YEAR_W-1:0]        result_year
);

   logic [cda_pkg::WDAY_W-1:0]   day_ff, day_in;
   logic [cda_pkg::WMON_W-1:0]   month_ff, month_in;
   logic [cda_pkg::WYEAR_W-1:0]  year_ff, year_in;
   logic [cda_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [cda_pkg::REM_W-1:0]    rem25_ff, rem25_in;
   logic [cda_pkg::DAY_W-1:0]    res_day_ff, res_day_in;
   logic [cda_pkg::MONTH_W-1:0]  res_month_ff, res_month_in;
   logic [cda_pkg::YEAR_W-1:0]   res_year_ff, res_year_in;

   logic [cda_pkg::MONTH_W-1:0]  start_month_fix;
   logic [cda_pkg::PROD_W-1:0]   prod;
   logic [cda_pkg::WYEAR_W-1:0]  rem_full;
   logic [cda_pkg::REM_W-1:0]    rem25_inc;
   logic                         leap;
   logic [cda_pkg::DAY_W-1:0]    dim;

   assign start_month_fix = (start_month == '0) ? cda_pkg::MONTH_JAN : start_month;

   assign prod     = cda_pkg::PROD_W'(year_ff) * cda_pkg::PROD_W'(cda_pkg::RECIP_25);
   assign rem_full = year_ff - cda_pkg::WYEAR_W'(quot_ff) * cda_pkg::DIVISOR_25;
   assign rem25_inc = (rem25_ff == cda_pkg::REM_25_LAST) ? '0 : rem25_ff + 1'b1;

   // leap: by 4 and not by 100, or by 400 (by 16 and by 25)
   assign leap = ((year_ff[1:0] == 2'b00) && (rem25_ff != '0)) ||
                 ((year_ff[3:0] == 4'b0000) && (rem25_ff == '0));
   assign dim  = cda_pkg::month_days(month_ff[cda_pkg::MONTH_W-1:0], leap);

   assign status.fold_more = (month_ff > cda_pkg::MONTHS_PER_YEAR);
   assign status.walk_more = (day_ff > cda_pkg::WDAY_W'(dim));

   always_comb begin
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      quot_in      = quot_ff;
      rem25_in     = rem25_ff;
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;

      if (cmd.load) begin
         day_in   = cda_pkg::WDAY_W'(start_day) + cda_pkg::WDAY_W'(add_days);
         month_in = cda_pkg::WMON_W'(start_month_fix) + cda_pkg::WMON_W'(add_months);
         year_in  = cda_pkg::WYEAR_W'(start_year) + cda_pkg::WYEAR_W'(add_years);
      end
      if (cmd.mod_div) begin
         quot_in = prod[cda_pkg::RECIP_SHIFT +: cda_pkg::QUOT_W];
      end
      if (cmd.mod_rem) begin
         rem25_in = rem_full[cda_pkg::REM_W-1:0];
      end
      if (cmd.fold_step) begin
         month_in = month_ff - cda_pkg::MONTHS_PER_YEAR;
         year_in  = year_ff + 1'b1;
         rem25_in = rem25_inc;
      end
      if (cmd.walk_step) begin
         day_in = day_ff - cda_pkg::WDAY_W'(dim);
         if (month_ff[cda_pkg::MONTH_W-1:0] == cda_pkg::MONTH_DEC) begin
            month_in = cda_pkg::WMON_W'(cda_pkg::MONTH_JAN);
            year_in  = year_ff + 1'b1;
            rem25_in = rem25_inc;
         end else begin
            month_in = month_ff + 1'b1;
         end
      end
      if (cmd.out_write) begin
         res_day_in   = day_ff[cda_pkg::DAY_W-1:0];
         res_month_in = month_ff[cda_pkg::MONTH_W-1:0];
         res_year_in  = (year_ff > cda_pkg::WYEAR_W'(cda_pkg::YEAR_MAX)) ?
                        cda_pkg::YEAR_MAX : year_ff[cda_pkg::YEAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      quot_ff      <= quot_in;
      rem25_ff     <= rem25_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
   end

   assign result_day   = res_day_ff;
   assign result_month = res_month_ff;
   assign result_year  = res_year_ff;

endmodule

// File: rtl/calendar_date_adder.sv
// top level of the calendar date adder: controller, datapath and checks
//
// adds an offset of days, months and years to a gregorian date and returns
// the normalized date, one request at a time. from acceptance to the result
// register a request passes the load, the residue divide and remainder,
// one fold step per whole year in the month sum (at most 22), one walk
// step per month length taken off the day sum (at most about 35) and the
// result write. the year residue mod 25 for the leap rule is taken once
// per request with a reciprocal multiply and then kept up to date as the
// year counts up. a start month of zero counts as january, a day of zero
// stays zero, a day past its month rolls into the next months, and the
// result year saturates at 16383 while leap years follow the full year.
// the result sits in an output register, so a new request is taken as
// soon as the last one has been written there.
module calendar_date_adder (
   input  logic       clock,
   input  logic       reset,
   cda_req_if.sink    req_chan,
   cda_rsp_if.source  rsp_chan
);

   // command and status between controller and datapath
   cda_pkg::cmd_type    cmd;
   cda_pkg::status_type status;

   // sequencing: load, residue, month fold, day walk, result write
   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // working date registers and the result register
   cda_datapath u_datapath (
      .clock        (clock),
      .start_day    (req_chan.start_day),
      .start_month  (req_chan.start_month),
      .start_year   (req_chan.start_year),
      .add_days     (req_chan.add_days),
      .add_months   (req_chan.add_months),
      .add_years    (req_chan.add_years),
      .cmd          (cmd),
      .status       (status),
      .result_day   (rsp_chan.result_day),
      .result_month (rsp_chan.result_month),
      .result_year  (rsp_chan.result_year)
   );

`ifndef SYNTHESIS
   // busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while previous one still in work");

   // result register never overwritten while holding an untaken result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // day walk only starts once the month sum is folded into range
   a_walk_after_fold: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !status.fold_more)
      else $error("day walk with month above december");

   // delivered month always a real month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.result_month >= cda_pkg::MONTH_JAN &&
                          rsp_chan.result_month <= cda_pkg::MONTH_DEC))
      else $error("result month out of range");
`endif

endmodule

// File: tb/calendar_date_adder_tb.sv
// testbench for the calendar date adder: directed, leap-rule, random and backpressure tests
`timescale 1ns / 100ps

module calendar_date_adder_tb;

   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES  = 80;    // settle time after the drain, for any stray result
   localparam int IDLE_PERCENT   = 13;

   typedef struct packed {
      logic [cda_pkg::DAY_W-1:0]   day;
      logic [cda_pkg::MONTH_W-1:0] month;
      logic [cda_pkg::YEAR_W-1:0]  year;
   } date_type;

   logic clock;
   logic reset;

   cda_req_if req_if ();
   cda_rsp_if rsp_if ();

   calendar_date_adder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // normalized dates still owed by the block, oldest first
   date_type expected_dates[$];

   int    mismatches     = 0;
   int    requests_sent  = 0;
   int    dates_checked  = 0;
   int    quiet_cycles   = 0;
   bit    tx_idle_en     = 1'b0;
   bit    rx_idle_en     = 1'b0;
   bit    hold_rsp_req   = 1'b0;
   int    hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // calendar predictor
   // ---------------------------------------------------------------

   // gregorian leap rule on the full, unclamped year
   function automatic bit is_leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      if (m == 32'(cda_pkg::MONTH_FEB))
         return is_leap_year(y) ? 32'(cda_pkg::FEB_LEAP_DAYS) : 28;
      case (m)
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // date after adding the offset fieldwise and walking the day sum off month by month
   function automatic date_type add_to_date(input logic [cda_pkg::DAY_W-1:0]      d0,
                                            input logic [cda_pkg::MONTH_W-1:0]    m0,
                                            input logic [cda_pkg::YEAR_W-1:0]     y0,
                                            input logic [cda_pkg::ADD_DAY_W-1:0]  ad,
                                            input logic [cda_pkg::ADD_MON_W-1:0]  am,
                                            input logic [cda_pkg::ADD_YEAR_W-1:0] ay);
      int unsigned d;
      int unsigned m;
      int unsigned y;
      date_type    res;
      d = 32'(d0);
      d = d + 32'(ad);
      // month zero counts as january
      m = (m0 == '0) ? 32'(cda_pkg::MONTH_JAN) : 32'(m0);
      m = m + 32'(am);
      y = 32'(y0);
      y = y + 32'(ay);
      // excess months fold into years, start months above twelve included
      while (m > 32'(cda_pkg::MONTHS_PER_YEAR)) begin
         m = m - 32'(cda_pkg::MONTHS_PER_YEAR);
         y++;
      end
      // day zero never enters this loop, so it comes out as zero
      while (d > month_length(m, y)) begin
         d = d - month_length(m, y);
         m++;
         if (m > 32'(cda_pkg::MONTHS_PER_YEAR)) begin
            m = 32'(cda_pkg::MONTH_JAN);
            y++;
         end
      end
      // only the reported year saturates
      if (y > 32'(cda_pkg::YEAR_MAX))
         y = 32'(cda_pkg::YEAR_MAX);
      res.day   = d[cda_pkg::DAY_W-1:0];
      res.month = m[cda_pkg::MONTH_W-1:0];
      res.year  = y[cda_pkg::YEAR_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------
   // request driver: drives at the falling edge, handshake seen at the rising edge
   // ---------------------------------------------------------------
   task automatic send_date(input int unsigned d,
                            input int unsigned m,
                            input int unsigned y,
                            input int unsigned ad,
                            input int unsigned am,
                            input int unsigned ay);
      logic [cda_pkg::DAY_W-1:0]      d_bits;
      logic [cda_pkg::MONTH_W-1:0]    m_bits;
      logic [cda_pkg::YEAR_W-1:0]     y_bits;
      logic [cda_pkg::ADD_DAY_W-1:0]  ad_bits;
      logic [cda_pkg::ADD_MON_W-1:0]  am_bits;
      logic [cda_pkg::ADD_YEAR_W-1:0] ay_bits;
      d_bits  = cda_pkg::DAY_W'(d);
      m_bits  = cda_pkg::MONTH_W'(m);
      y_bits  = cda_pkg::YEAR_W'(y);
      ad_bits = cda_pkg::ADD_DAY_W'(ad);
      am_bits = cda_pkg::ADD_MON_W'(am);
      ay_bits = cda_pkg::ADD_YEAR_W'(ay);
      @(negedge clock);
      // random gap before this request, one assignment per falling edge
      while (tx_idle_en && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.start_day   <= d_bits;
      req_if.start_month <= m_bits;
      req_if.start_year  <= y_bits;
      req_if.add_days    <= ad_bits;
      req_if.add_months  <= am_bits;
      req_if.add_years   <= ay_bits;
      do
         @(posedge clock);
      while (!req_if.ready);
      expected_dates.push_back(add_to_date(d_bits, m_bits, y_bits, ad_bits, am_bits, ay_bits));
      requests_sent++;
   endtask

   // sender pauses with valid low until every owed date has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_dates.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // response sink: random ready, plus a long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(rx_idle_en && ($urandom_range(99) < IDLE_PERCENT));
         end
      end
   end

   // ---------------------------------------------------------------
   // result checker against the oldest owed date
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      date_type got;
      date_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.day   = rsp_if.result_day;
         got.month = rsp_if.result_month;
         got.year  = rsp_if.result_year;
         if (expected_dates.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result %0d/%0d/%0d with no request pending",
                     $time, got.day, got.month, got.year);
         end else begin
            want = expected_dates.pop_front();
            dates_checked++;
            if (got !== want) begin
               mismatches++;
               $display("%0t: mismatch day/month/year expected %0d/%0d/%0d actual %0d/%0d/%0d",
                        $time, want.day, want.month, want.year,
                        got.day, got.month, got.year);
            end
         end
      end
   end

   // watchdog: ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still owed",
                  $time, expected_dates.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // field extremes: every field at its top, offsets also at zero
   task automatic test_field_extremes();
      send_date(1, 1, 1, 0, 0, 0);
      send_date(31, 12, 9999, 1023, 255, 255);
      send_date(31, 12, 9999, 0, 0, 0);
      send_date(1, 1, 1, 1023, 0, 0);
      send_date(15, 6, 2000, 0, 255, 0);
      send_date(15, 6, 2000, 0, 0, 255);
      send_date(31, 15, 16383, 1023, 255, 255);   // every input bit set
      wait_for_results();
   endtask

   // the odd corners of the calendar
   task automatic test_special_cases();
      send_date(10, 0, 2023, 5, 0, 0);      // month zero taken as january
      send_date(10, 0, 2023, 0, 11, 0);     // month zero plus months
      send_date(5, 13, 2023, 0, 0, 0);      // month above twelve folds into a year
      send_date(5, 15, 2023, 0, 0, 0);
      send_date(0, 3, 2023, 0, 0, 0);       // day zero stays zero
      send_date(0, 3, 2023, 1, 0, 0);
      send_date(31, 2, 2023, 0, 0, 0);      // day past its month rolls forward
      send_date(31, 2, 2024, 0, 0, 0);
      send_date(31, 1, 2023, 0, 1, 0);      // january 31 plus one month
      send_date(29, 2, 0, 0, 0, 0);         // year zero is a leap year
      send_date(1, 2, 0, 28, 0, 0);
      send_date(1, 1, 16383, 0, 0, 0);      // year at the clamp
      send_date(28, 2, 16383, 1, 0, 1);     // leap rule on the unclamped year
      send_date(28, 2, 1900, 1, 0, 0);      // century years
      send_date(28, 2, 2000, 1, 0, 0);
      send_date(28, 2, 2100, 1, 0, 0);
      send_date(31, 12, 1999, 1, 0, 0);     // year rollover
      wait_for_results();
   endtask

   // walks across february around century, quad-century, leap and ordinary years
   task automatic test_leap_walks();
      for (int i = 0; i < 150; i++) begin
         int unsigned y;
         int unsigned m;
         case ($urandom_range(3))
            0:       y = 100 * $urandom_range(99, 1);
            1:       y = 400 * $urandom_range(24, 1);
            2:       y = 4 * $urandom_range(2499, 1);
            default: y = $urandom_range(9999, 1);
         endcase
         m = $urandom_range(3, 1);
         send_date($urandom_range(month_length(m, y), 1), m, y - $urandom_range(1),
                   $urandom_range(1023), $urandom_range(2), $urandom_range(1));
      end
      wait_for_results();
   endtask

   // valid dates with random offsets; the first stretch runs with no idling at all
   task automatic test_random_dates();
      for (int i = 0; i < 1200; i++) begin
         int unsigned y;
         int unsigned m;
         int unsigned ad;
         int unsigned am;
         int unsigned ay;
         if (i == 300) begin
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
         end
         y  = $urandom_range(9999, 1);
         m  = $urandom_range(12, 1);
         ad = $urandom_range(1) ? $urandom_range(60) : $urandom_range(1023);
         am = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(24);
         ay = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(10);
         send_date($urandom_range(month_length(m, y), 1), m, y, ad, am, ay);
      end
      wait_for_results();
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      for (int burst = 0; burst < 3; burst++) begin
         hold_rsp_req = 1'b1;
         for (int i = 0; i < 20; i++)
            send_date($urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1),
                      $urandom_range(1023), $urandom_range(255), $urandom_range(255));
         wait_for_results();
      end
   endtask

   // any bit pattern the fields allow, out-of-range ones included
   task automatic test_raw_fields();
      for (int i = 0; i < 400; i++)
         send_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      wait_for_results();
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.start_day   = '0;
      req_if.start_month = '0;
      req_if.start_year  = '0;
      req_if.add_days    = '0;
      req_if.add_months  = '0;
      req_if.add_years   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_special_cases();
      test_leap_walks();
      test_random_dates();
      test_backpressure();
      test_raw_fields();

      // drained; leave room for any stray result
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d results checked, %0d mismatches", requests_sent,
               dates_checked, mismatches);
      $display("field extremes, odd calendar corners, leap walks, random dates, raw fields, "
               , "long receiver hold-off");
      if (mismatches == 0 && expected_dates.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
